/* rtl/psd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_pkg
// Widths, codes and bus types shared by the point to segment distance core.
// ----------------------------------------------------------------------------
package psd_pkg;

    // coordinate width, signed Q8.8
    localparam int CW = 16;
    // coordinate difference, product and three-term sum widths
    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;
    localparam int LW = PW + 2;
    // half of a cross component magnitude
    localparam int HW = PW / 2;
    // squared distance numerator width
    localparam int NW = 2 * PW + 2;
    // fraction bits added before the root
    localparam int FRAC_SHIFT = 16;
    localparam int RW = NW + FRAC_SHIFT;
    // result width
    localparam int DIST_BITS = 25;
    localparam int BIT_W = $clog2(DIST_BITS);
    // running y * den width and root cell compare width
    localparam int YW = LW + DIST_BITS;
    localparam int TW = ((RW > YW + DIST_BITS) ? RW : YW + DIST_BITS) + 2;
    // pipeline depth of the front end
    localparam int FRONT_STAGES = 5;

    localparam logic [1:0] KIND_INTERIOR = 2'd0;
    localparam logic [1:0] KIND_START    = 2'd1;
    localparam logic [1:0] KIND_END      = 2'd2;

    typedef struct packed {
        logic signed [CW-1:0] point_x;
        logic signed [CW-1:0] point_y;
        logic signed [CW-1:0] point_z;
        logic signed [CW-1:0] start_x;
        logic signed [CW-1:0] start_y;
        logic signed [CW-1:0] start_z;
        logic signed [CW-1:0] end_x;
        logic signed [CW-1:0] end_y;
        logic signed [CW-1:0] end_z;
    } t_query;

    // front end result: squared numerator over denominator
    typedef struct packed {
        logic          valid;
        logic [1:0]    kind;
        logic [NW-1:0] num;
        logic [LW-1:0] den;
    } t_front;

    // word handed from root cell to root cell
    typedef struct packed {
        logic                 valid;
        logic [1:0]           kind;
        logic [TW-1:0]        rem;
        logic [LW-1:0]        den;
        logic [YW-1:0]        yden;
        logic [DIST_BITS-1:0] y;
    } t_root_bus;

endpackage

/* rtl/psd_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_if
// Valid/ready channels for query words and distance words.
// ----------------------------------------------------------------------------
interface psd_in_if;
    import psd_pkg::*;
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] point_z;
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] start_z;
    logic signed [CW-1:0] end_x;
    logic signed [CW-1:0] end_y;
    logic signed [CW-1:0] end_z;

    modport source (
        output valid, point_x, point_y, point_z, start_x, start_y, start_z,
               end_x, end_y, end_z,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, point_z, start_x, start_y, start_z,
               end_x, end_y, end_z,
        output ready
    );
endinterface

interface psd_out_if;
    import psd_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [DIST_BITS-1:0] distance;
    logic [1:0]           nearest_kind;

    modport source (output valid, distance, nearest_kind, input ready);
    modport sink (input valid, distance, nearest_kind, output ready);
endinterface

/* rtl/psd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_front
// Five-stage front end: differences, products, sums, case decision and
// numerator assembly for the root chain.
// ----------------------------------------------------------------------------
module psd_front
    import psd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  logic   i_valid,
    input  t_query i_query,
    output t_front o_front
);

    logic [FRONT_STAGES-1:0] r_vld;

    logic signed [DW-1:0] r_d [3];
    logic signed [DW-1:0] r_e [3];
    logic signed [DW-1:0] r_f [3];
    logic signed [DW-1:0] n_d [3];
    logic signed [DW-1:0] n_e [3];
    logic signed [DW-1:0] n_f [3];

    logic signed [PW-1:0] r_ee [3];
    logic signed [PW-1:0] r_de [3];
    logic signed [PW-1:0] r_dd [3];
    logic signed [PW-1:0] r_ff [3];
    logic signed [PW-1:0] r_cp [3];
    logic signed [PW-1:0] r_cn [3];

    logic [LW-1:0]        r_len2;
    logic signed [LW-1:0] r_t;
    logic [LW-1:0]        r_dsq;
    logic [LW-1:0]        r_fsq;
    logic [PW-1:0]        r_cabs [3];
    logic [LW-1:0]        n_len2;
    logic signed [LW-1:0] n_t;
    logic [LW-1:0]        n_dsq;
    logic [LW-1:0]        n_fsq;
    logic [PW-1:0]        n_cabs [3];

    logic [1:0]    r_kind3;
    logic [1:0]    n_kind3;
    logic [LW-1:0] r_den3;
    logic [LW-1:0] r_dist3;
    logic [LW-1:0] n_dist3;
    logic [PW-1:0] r_hh [3];
    logic [PW-1:0] r_hl [3];
    logic [PW-1:0] r_ll [3];
    logic signed [LW:0] w_rest;

    logic [1:0]    r_kind4;
    logic [NW-1:0] r_num4;
    logic [LW-1:0] r_den4;
    logic [NW-1:0] n_num4;

    // valid bits follow the words through the stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[FRONT_STAGES-2:0], i_valid};
        end
    end

    // stage 0: coordinate differences P-A, B-A, P-B
    always_comb begin
        n_d[0] = DW'(i_query.point_x) - DW'(i_query.start_x);
        n_d[1] = DW'(i_query.point_y) - DW'(i_query.start_y);
        n_d[2] = DW'(i_query.point_z) - DW'(i_query.start_z);
        n_e[0] = DW'(i_query.end_x) - DW'(i_query.start_x);
        n_e[1] = DW'(i_query.end_y) - DW'(i_query.start_y);
        n_e[2] = DW'(i_query.end_z) - DW'(i_query.start_z);
        n_f[0] = DW'(i_query.point_x) - DW'(i_query.end_x);
        n_f[1] = DW'(i_query.point_y) - DW'(i_query.end_y);
        n_f[2] = DW'(i_query.point_z) - DW'(i_query.end_z);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
            r_e <= n_e;
            r_f <= n_f;
        end
    end

    // stage 1: all products, one multiplier each
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_ee[k] <= r_e[k] * r_e[k];
                r_de[k] <= r_d[k] * r_e[k];
                r_dd[k] <= r_d[k] * r_d[k];
                r_ff[k] <= r_f[k] * r_f[k];
                r_cp[k] <= r_d[(k + 1) % 3] * r_e[(k + 2) % 3];
                r_cn[k] <= r_d[(k + 2) % 3] * r_e[(k + 1) % 3];
            end
        end
    end

    // stage 2: squared length, projection dot, endpoint distances, cross magnitudes
    always_comb begin
        logic signed [PW:0] c;
        n_len2 = LW'(r_ee[0]) + LW'(r_ee[1]) + LW'(r_ee[2]);
        n_t    = LW'(r_de[0]) + LW'(r_de[1]) + LW'(r_de[2]);
        n_dsq  = LW'(r_dd[0]) + LW'(r_dd[1]) + LW'(r_dd[2]);
        n_fsq  = LW'(r_ff[0]) + LW'(r_ff[1]) + LW'(r_ff[2]);
        for (int k = 0; k < 3; k++) begin
            c = (PW+1)'(r_cp[k]) - (PW+1)'(r_cn[k]);
            n_cabs[k] = c[PW] ? PW'(-c) : PW'(c);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_len2 <= n_len2;
            r_t    <= n_t;
            r_dsq  <= n_dsq;
            r_fsq  <= n_fsq;
            r_cabs <= n_cabs;
        end
    end

    // stage 3: pick the nearest feature, split cross squares into partials
    assign w_rest = (LW+1)'(r_len2) - (LW+1)'(r_t);

    always_comb begin
        priority if (r_len2 == '0 || r_t[LW-1]) begin
            n_kind3 = KIND_START;
            n_dist3 = r_dsq;
        end else if (w_rest[LW]) begin
            n_kind3 = KIND_END;
            n_dist3 = r_fsq;
        end else begin
            n_kind3 = KIND_INTERIOR;
            n_dist3 = r_dsq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_kind3 <= n_kind3;
            r_dist3 <= n_dist3;
            r_den3  <= r_len2;
            for (int k = 0; k < 3; k++) begin
                r_hh[k] <= r_cabs[k][PW-1:HW] * r_cabs[k][PW-1:HW];
                r_hl[k] <= r_cabs[k][PW-1:HW] * r_cabs[k][HW-1:0];
                r_ll[k] <= r_cabs[k][HW-1:0] * r_cabs[k][HW-1:0];
            end
        end
    end

    // stage 4: assemble numerator and denominator
    always_comb begin
        n_num4 = '0;
        if (r_kind3 == KIND_INTERIOR) begin
            for (int k = 0; k < 3; k++) begin
                n_num4 = n_num4 + (NW'(r_hh[k]) << PW) + (NW'(r_hl[k]) << (HW + 1))
                       + NW'(r_ll[k]);
            end
        end else begin
            n_num4 = NW'(r_dist3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_kind4 <= r_kind3;
            r_num4  <= n_num4;
            r_den4  <= (r_kind3 == KIND_INTERIOR) ? r_den3 : LW'(1);
        end
    end

    assign o_front.valid = r_vld[FRONT_STAGES-1];
    assign o_front.kind  = r_kind4;
    assign o_front.num   = r_num4;
    assign o_front.den   = r_den4;

endmodule

/* rtl/psd_root_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_root_cell
// One cell of the root chain: decides one bit of y = floor(sqrt(num/den))
// by keeping rem = num - y*y*den and yden = y*den.
// ----------------------------------------------------------------------------
module psd_root_cell
    import psd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [BIT_W-1:0] i_bit,
    input  t_root_bus        i_bus,
    output t_root_bus        o_bus
);

    logic             r_valid;
    logic [1:0]       r_kind;
    logic [TW-1:0]    r_rem;
    logic [LW-1:0]    r_den;
    logic [YW-1:0]    r_yden;
    logic [DIST_BITS-1:0] r_y;

    logic [TW-1:0]    w_test;
    logic             w_take;
    logic [BIT_W:0]   w_sh1;
    logic [BIT_W:0]   w_sh2;

    // trial term (2y*2^b + 4^b) * den
    assign w_sh1  = {1'b0, i_bit} + (BIT_W+1)'(1);
    assign w_sh2  = {i_bit, 1'b0};
    assign w_test = (TW'(i_bus.yden) << w_sh1) + (TW'(i_bus.den) << w_sh2);
    assign w_take = (i_bus.rem >= w_test);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_bus.valid;
        end
    end

    // advance the word, keeping the bit when it fits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_kind <= i_bus.kind;
            r_den  <= i_bus.den;
            if (w_take) begin
                r_rem  <= i_bus.rem - w_test;
                r_yden <= i_bus.yden + (YW'(i_bus.den) << i_bit);
                r_y    <= i_bus.y | (DIST_BITS'(1) << i_bit);
            end else begin
                r_rem  <= i_bus.rem;
                r_yden <= i_bus.yden;
                r_y    <= i_bus.y;
            end
        end
    end

    assign o_bus.valid = r_valid;
    assign o_bus.kind  = r_kind;
    assign o_bus.rem   = r_rem;
    assign o_bus.den   = r_den;
    assign o_bus.yden  = r_yden;
    assign o_bus.y     = r_y;

endmodule

/* rtl/point_segment_distance_3d_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_segment_distance_3d_core
// Distance from a point to a 3D segment, Q8.8 in, 16 fraction bits out.
// ----------------------------------------------------------------------------
// Usage:
//   i_query takes one word per cycle while the pipe does not hold: point, segment
//   start and segment end, each coordinate signed Q8.8. o_result gives one word per query, in order:
//   the truncated distance and the kind of nearest feature (interior, start
//   or degenerate, end).
//   From acceptance to o_result.valid a word passes five front-end stages
//   (differences, products, sums, case decision, numerator) and a chain of
//   25 root cells, one result bit per cell, the last cell being the output
//   register. Throughput is one word per cycle while o_result is not stalled.
//   When the receiver holds o_result.ready low with a word waiting, the whole
//   pipe holds and i_query.ready drops; it rises again as soon as the word
//   is taken. Reset clears every valid bit; no word is in flight after it.
// ----------------------------------------------------------------------------
module point_segment_distance_3d_core
    import psd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    psd_in_if.sink    i_query,
    psd_out_if.source o_result
);

    t_query    w_query;
    t_front    w_front;
    logic      w_en;
    t_root_bus w_bus [DIST_BITS+1];

    // hold everything while a finished word waits
    assign w_en = !w_bus[DIST_BITS].valid || o_result.ready;
    assign i_query.ready = w_en;

    assign w_query.point_x = i_query.point_x;
    assign w_query.point_y = i_query.point_y;
    assign w_query.point_z = i_query.point_z;
    assign w_query.start_x = i_query.start_x;
    assign w_query.start_y = i_query.start_y;
    assign w_query.start_z = i_query.start_z;
    assign w_query.end_x   = i_query.end_x;
    assign w_query.end_y   = i_query.end_y;
    assign w_query.end_z   = i_query.end_z;

    psd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_query.valid),
        .i_query (w_query),
        .o_front (w_front)
    );

    // seed the root chain with num shifted up by FRAC_SHIFT, for 16 fraction bits out
    assign w_bus[0].valid = w_front.valid;
    assign w_bus[0].kind  = w_front.kind;
    assign w_bus[0].rem   = TW'(w_front.num) << FRAC_SHIFT;
    assign w_bus[0].den   = w_front.den;
    assign w_bus[0].yden  = '0;
    assign w_bus[0].y     = '0;

    for (genvar g = 0; g < DIST_BITS; g++) begin : g_cell
        psd_root_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_bit   (BIT_W'(DIST_BITS - 1 - g)),
            .i_bus   (w_bus[g]),
            .o_bus   (w_bus[g+1])
        );
    end

    assign o_result.valid        = w_bus[DIST_BITS].valid;
    assign o_result.distance     = w_bus[DIST_BITS].y;
    assign o_result.nearest_kind = w_bus[DIST_BITS].kind;

endmodule

/* rtl/psd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_checker
// Port-level checks on the distance core, bound to the top level.
// ----------------------------------------------------------------------------
module psd_checker
    import psd_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic [DIST_BITS-1:0] i_distance,
    input logic [1:0]           i_kind
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_distance)
        && $stable(i_kind))
        else $error("result word changed while stalled");

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result word valid right after reset");

    // input only blocks behind a stalled result
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input blocked without output stall");

    // kind code is one of the three meaningful values
    a_kind_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_kind == KIND_INTERIOR || i_kind == KIND_START
        || i_kind == KIND_END))
        else $error("undefined nearest kind");

endmodule

bind point_segment_distance_3d_core psd_checker u_psd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_query.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_distance  (o_result.distance),
    .i_kind      (o_result.nearest_kind)
);
